### rtl/core/bba_pkg.sv
// Shared types, codes and fixed widths of the bitmap block allocator.
package bba_pkg;

	localparam int BLOCK_W    = 18;
	localparam int TOTAL_W    = 18;
	localparam int GCOUNT_W   = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA_BLOCK = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GROUPS_IN_USE    = CFG_IDX_W'(1);

	// Request actions
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// Result status codes
	localparam logic [1:0] STAT_ALLOC   = 2'd0;
	localparam logic [1:0] STAT_NONE    = 2'd1;
	localparam logic [1:0] STAT_FREED   = 2'd2;
	localparam logic [1:0] STAT_IGNORED = 2'd3;

	typedef struct packed {
		logic               action;
		logic [BLOCK_W-1:0] block_in;
	} req_word_t;

	typedef struct packed {
		logic [BLOCK_W-1:0] block_out;
		logic [1:0]         status;
		logic [TOTAL_W-1:0] free_total_out;
	} rsp_word_t;

	// Bitmap memory port control
	typedef struct packed {
		logic rd;
		logic wr;
	} map_ctl_t;

	// Group counter memory port control; a write stores the reset value,
	// the read value plus one, or the read value minus one
	typedef struct packed {
		logic rd;
		logic wr;
		logic init;
		logic inc;
	} cnt_ctl_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_GRP,
		ST_GCHK,
		ST_SCAN,
		ST_COMMIT,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_FIN
	} fsm_state_t;

endpackage

### rtl/core/bba_map.sv
// Allocation bitmap memory with lowest-clear-bit finder on the read word.
module bba_map #(
	parameter int WORD_BITS = 64,
	parameter int DEPTH     = 2048
) (
	input  logic                                     clk,
	input  bba_pkg::map_ctl_t                        ctl,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WORD_BITS-1:0]                     wdata,
	output logic [WORD_BITS-1:0]                     rdata,
	output logic [WORD_BITS-1:0]                     set_word,
	output logic [$clog2(WORD_BITS)-1:0]             low_pos,
	output logic                                     full
);
	import bba_pkg::*;

	localparam int WBW = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0] mem_q [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;
	logic [WORD_BITS-1:0] inv;
	logic [WORD_BITS-1:0] low_hot;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem_q[addr];
		end
	end

	// isolate the lowest clear bit, then encode it
	always_comb begin
		inv     = ~rdata_q;
		low_hot = inv & (~inv + WORD_BITS'(1));
		low_pos = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			if (low_hot[j]) begin
				low_pos = low_pos | WBW'(j);
			end
		end
	end

	assign rdata    = rdata_q;
	assign set_word = rdata_q | low_hot;
	assign full     = &rdata_q;

endmodule

### rtl/core/bba_counts.sv
// Per-group free counter memory with reset-value, increment and decrement write-back.
module bba_counts #(
	parameter int NUM_GROUPS       = 16,
	parameter int BLOCKS_PER_GROUP = 8192
) (
	input  logic                                               clk,
	input  bba_pkg::cnt_ctl_t                                  ctl,
	input  logic [((NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1)-1:0] addr,
	output logic                                               zero
);
	import bba_pkg::*;

	localparam logic [GCOUNT_W-1:0] CNT_RST = GCOUNT_W'(BLOCKS_PER_GROUP);

	logic [GCOUNT_W-1:0] mem_q [NUM_GROUPS];
	logic [GCOUNT_W-1:0] rdata_q;
	logic [GCOUNT_W-1:0] wdata;

	always_comb begin
		if (ctl.init) begin
			wdata = CNT_RST;
		end else if (ctl.inc) begin
			wdata = rdata_q + GCOUNT_W'(1);
		end else begin
			wdata = rdata_q - GCOUNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign zero = (rdata_q == '0);

endmodule

### rtl/core/bitmap_block_allocator.sv
// First-fit bitmap block allocator: sequencer, counters, config and result register.
//
// First-fit block allocator over NUM_GROUPS groups of BLOCKS_PER_GROUP blocks,
// one bitmap bit per block (set = used), held in a single-port synchronous
// memory of WORD_BITS-bit words. BLOCKS_PER_GROUP and WORD_BITS are powers of
// two, with WORD_BITS dividing BLOCKS_PER_GROUP. After reset the block runs a
// clearing pass over all NUM_GROUPS*BLOCKS_PER_GROUP/WORD_BITS bitmap words
// (2048 at the defaults) that zeroes the bitmap and loads every group counter;
// req_ready stays low until it ends, while configuration writes are taken at
// any time. One request is worked on at a time. A free of a block in a group
// in use reads the bitmap word and the group counter, then writes both back,
// then loads the result register; an ignored free or an allocate with no
// groups in use goes straight to loading the result. An allocate reads the
// counter of each group visited and, for each group whose counter is non-zero,
// reads the bitmap word by word (one word per cycle, 128 words per default
// group) until a word with a clear bit comes back, then writes that word and
// the counter back and loads the result. The result register parts the two
// channels, so the next request may be accepted while a result word still
// waits on rsp_ready. Groups beyond NUM_GROUPS are clamped; frees of block 0
// or outside the groups in use are ignored.
module bitmap_block_allocator #(
	parameter int BLOCKS_PER_GROUP = 8192,
	parameter int NUM_GROUPS       = 16,
	parameter int WORD_BITS        = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  bba_pkg::req_word_t                  req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output bba_pkg::rsp_word_t                  rsp,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bba_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bba_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bba_pkg::*;

	localparam int WPG       = BLOCKS_PER_GROUP / WORD_BITS;
	localparam int MAP_WORDS = NUM_GROUPS * WPG;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int GIW       = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int GW        = $clog2(NUM_GROUPS + 1);
	localparam int EW        = (GW > CFG_DATA_W) ? GW : CFG_DATA_W;
	localparam int KW        = (WPG > 1) ? $clog2(WPG) : 1;
	localparam int KCW       = $clog2(WPG + 1);
	localparam int WBW       = $clog2(WORD_BITS);
	localparam int BPW       = $clog2(BLOCKS_PER_GROUP);
	localparam int FW        = GIW + BPW;
	localparam int NW        = (FW > BLOCK_W) ? FW : BLOCK_W;

	localparam logic [TOTAL_W-1:0] TOTAL_RST = TOTAL_W'(NUM_GROUPS * BLOCKS_PER_GROUP);
	localparam logic [AW-1:0]      CLR_LAST  = AW'(MAP_WORDS - 1);
	localparam logic [KW-1:0]      WIDX_LAST = KW'(WPG - 1);

	fsm_state_t state_q, state_nxt;

	// control registers
	logic [AW-1:0]         clr_q;
	logic                  first_data_block_q;
	logic [CFG_DATA_W-1:0] groups_in_use_q;
	logic [TOTAL_W-1:0]    free_total_q;
	logic [GIW-1:0]        g_q;
	logic [KCW-1:0]        k_q;
	logic                  vld_s1;
	logic                  rsp_valid_q;

	// payload registers
	logic [KW-1:0]         widx_s1;
	logic [AW-1:0]         hit_addr_q;
	logic [BPW-1:0]        hit_bit_q;
	logic [WORD_BITS-1:0]  hit_word_q;
	logic [AW-1:0]         fw_addr_q;
	logic [WBW-1:0]        fbit_q;
	logic [GIW-1:0]        fg_q;
	logic [BLOCK_W-1:0]    res_block_q;
	logic [1:0]            res_status_q;
	rsp_word_t             rsp_q;

	// memory ports
	map_ctl_t              map_ctl;
	logic [AW-1:0]         map_addr;
	logic [WORD_BITS-1:0]  map_wdata;
	logic [WORD_BITS-1:0]  map_rdata;
	logic [WORD_BITS-1:0]  map_set_word;
	logic [WBW-1:0]        map_pos;
	logic                  map_full;
	cnt_ctl_t              cnt_ctl;
	logic [GIW-1:0]        cnt_addr;
	logic                  cnt_zero;

	// derived terms
	logic [GW-1:0]         eff_groups;
	logic [GW-1:0]         g_next;
	logic                  last_grp;
	logic                  accept;
	logic [BLOCK_W-1:0]    rel;
	logic [BLOCK_W-1:0]    rel_g;
	logic                  free_ok;
	logic                  issue;
	logic                  hit;
	logic                  grp_done;
	logic [NW-1:0]         num_w;
	logic [BLOCK_W-1:0]    num;
	logic                  rsp_load;
	logic                  clr_cnt;

	bba_map #(
		.WORD_BITS (WORD_BITS),
		.DEPTH     (MAP_WORDS)
	) u_map (
		.clk      (clk),
		.ctl      (map_ctl),
		.addr     (map_addr),
		.wdata    (map_wdata),
		.rdata    (map_rdata),
		.set_word (map_set_word),
		.low_pos  (map_pos),
		.full     (map_full)
	);

	bba_counts #(
		.NUM_GROUPS       (NUM_GROUPS),
		.BLOCKS_PER_GROUP (BLOCKS_PER_GROUP)
	) u_counts (
		.clk  (clk),
		.ctl  (cnt_ctl),
		.addr (cnt_addr),
		.zero (cnt_zero)
	);

	// groups_in_use clamps to the groups that exist
	always_comb begin
		if (EW'(groups_in_use_q) > EW'(NUM_GROUPS)) begin
			eff_groups = GW'(NUM_GROUPS);
		end else begin
			eff_groups = GW'(groups_in_use_q);
		end
	end

	assign g_next   = GW'(g_q) + GW'(1);
	assign last_grp = (g_next >= eff_groups);
	assign accept   = req_valid && req_ready;

	// free target: relative block, its group, word and bit
	assign rel     = req.block_in - BLOCK_W'(first_data_block_q);
	assign rel_g   = rel >> BPW;
	assign free_ok = (req.block_in != '0) && (rel_g < BLOCK_W'(eff_groups));

	// scan: one word read issued per cycle, checked in the following cycle
	assign issue    = (state_q == ST_SCAN) && (k_q < KCW'(WPG));
	assign hit      = vld_s1 && !map_full;
	assign grp_done = vld_s1 && map_full && (widx_s1 == WIDX_LAST);

	// block number of the hit; a sum of zero is never handed out
	assign num_w = NW'(first_data_block_q) + NW'(g_q) * NW'(BLOCKS_PER_GROUP)
	             + NW'(hit_bit_q);
	assign num   = num_w[BLOCK_W-1:0];

	assign rsp_load = (state_q == ST_FIN) && (!rsp_valid_q || rsp_ready);
	assign clr_cnt  = (int'(clr_q) < NUM_GROUPS);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					if (req.action == ACT_FREE) begin
						state_nxt = free_ok ? ST_FREE_RD : ST_FIN;
					end else begin
						state_nxt = (eff_groups == '0) ? ST_FIN : ST_GRP;
					end
				end
			end
			ST_GRP: begin
				state_nxt = ST_GCHK;
			end
			ST_GCHK: begin
				if (!cnt_zero) begin
					state_nxt = ST_SCAN;
				end else begin
					state_nxt = last_grp ? ST_FIN : ST_GRP;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					state_nxt = ST_COMMIT;
				end else if (grp_done) begin
					state_nxt = last_grp ? ST_FIN : ST_GRP;
				end
			end
			ST_COMMIT: begin
				if (num != '0 || last_grp) begin
					state_nxt = ST_FIN;
				end else begin
					state_nxt = ST_GRP;
				end
			end
			ST_FREE_RD: begin
				state_nxt = ST_FREE_WR;
			end
			ST_FREE_WR: begin
				state_nxt = ST_FIN;
			end
			ST_FIN: begin
				if (rsp_load) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	// memory port and handshake outputs
	always_comb begin
		req_ready = 1'b0;
		map_ctl   = '0;
		map_addr  = '0;
		map_wdata = '0;
		cnt_ctl   = '0;
		cnt_addr  = '0;
		case (state_q)
			ST_CLEAR: begin
				map_ctl.wr   = 1'b1;
				map_addr     = clr_q;
				cnt_ctl.wr   = clr_cnt;
				cnt_ctl.init = 1'b1;
				cnt_addr     = GIW'(clr_q);
			end
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_GRP: begin
				cnt_ctl.rd = 1'b1;
				cnt_addr   = g_q;
			end
			ST_SCAN: begin
				map_ctl.rd = issue;
				map_addr   = AW'(int'(g_q) * WPG + int'(k_q[KW-1:0]));
			end
			ST_COMMIT: begin
				map_ctl.wr = 1'b1;
				map_addr   = hit_addr_q;
				map_wdata  = hit_word_q;
				cnt_ctl.wr = 1'b1;
				cnt_addr   = g_q;
			end
			ST_FREE_RD: begin
				map_ctl.rd = 1'b1;
				map_addr   = fw_addr_q;
				cnt_ctl.rd = 1'b1;
				cnt_addr   = fg_q;
			end
			ST_FREE_WR: begin
				map_ctl.wr  = 1'b1;
				map_addr    = fw_addr_q;
				map_wdata   = map_rdata & ~(WORD_BITS'(1) << fbit_q);
				cnt_ctl.wr  = 1'b1;
				cnt_ctl.inc = 1'b1;
				cnt_addr    = fg_q;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_CLEAR;
			clr_q              <= '0;
			first_data_block_q <= 1'b1;
			groups_in_use_q    <= CFG_DATA_W'(16);
			free_total_q       <= TOTAL_RST;
			g_q                <= '0;
			k_q                <= '0;
			vld_s1             <= 1'b0;
			rsp_valid_q        <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_FIRST_DATA_BLOCK: first_data_block_q <= cfg_data[0];
					REG_GROUPS_IN_USE:    groups_in_use_q    <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == ST_COMMIT) begin
				free_total_q <= free_total_q - TOTAL_W'(1);
			end else if (state_q == ST_FREE_WR) begin
				free_total_q <= free_total_q + TOTAL_W'(1);
			end
			// group pointer: reset on accept, step when a group is passed over
			if (accept) begin
				g_q <= '0;
			end else if (state_nxt == ST_GRP && state_q != ST_IDLE) begin
				g_q <= GIW'(g_next);
			end
			if (state_q == ST_GCHK) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + KCW'(1);
			end
			vld_s1 <= issue;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		widx_s1 <= k_q[KW-1:0];
		if (state_q == ST_SCAN && hit) begin
			hit_addr_q <= AW'(int'(g_q) * WPG + int'(widx_s1));
			hit_bit_q  <= BPW'(int'(widx_s1) * WORD_BITS + int'(map_pos));
			hit_word_q <= map_set_word;
		end
		if (accept) begin
			fw_addr_q    <= AW'(rel >> WBW);
			fbit_q       <= rel[WBW-1:0];
			fg_q         <= GIW'(rel_g);
			res_block_q  <= '0;
			res_status_q <= (req.action == ACT_FREE) ? STAT_IGNORED : STAT_NONE;
		end else if (state_q == ST_COMMIT && num != '0) begin
			res_block_q  <= num;
			res_status_q <= STAT_ALLOC;
		end else if (state_q == ST_FREE_WR) begin
			res_status_q <= STAT_FREED;
		end
		if (rsp_load) begin
			rsp_q.block_out      <= res_block_q;
			rsp_q.status         <= res_status_q;
			rsp_q.free_total_out <= free_total_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

`ifndef ASSERT_OFF
	a_commit_dec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COMMIT |=> free_total_q + TOTAL_W'(1) == $past(free_total_q))
		else $error("total counter not decremented on bitmap commit");

	a_free_inc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FREE_WR |=> free_total_q == $past(free_total_q) + TOTAL_W'(1))
		else $error("total counter not incremented on free");

	a_alloc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_ALLOC |-> rsp.block_out != '0)
		else $error("block zero handed out");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_FIN))
		else $error("result word loaded outside the finish state");

	a_map_port: assert property (@(posedge clk) disable iff (!arst_n)
		map_ctl.wr |-> !map_ctl.rd && !issue)
		else $error("bitmap read and write in the same cycle");
`endif

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the first-fit bitmap block allocator.
module tb;
	import bba_pkg::*;

	// Sizes the allocator is built with; the shadow allocator below uses the same
	localparam int BLOCKS_PER_GROUP = 8192;
	localparam int NUM_GROUPS       = 16;
	localparam int WORD_BITS        = 64;
	localparam int WORDS_PER_GROUP  = BLOCKS_PER_GROUP / WORD_BITS;
	localparam int MAP_WORDS        = NUM_GROUPS * WORDS_PER_GROUP;

	// Register indexes that decode to nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

	// Receiver hold-off, in cycles, used to back the allocator up
	localparam int LONG_HOLD = 300;

	// Settings of the first random phases; the last ones draw their own
	localparam logic [CFG_DATA_W-1:0] PHASE_FIRST  [6] = '{5'd1, 5'd0, 5'd1, 5'd0, 5'd3, 5'd0};
	localparam logic [CFG_DATA_W-1:0] PHASE_GROUPS [6] = '{5'd16, 5'd2, 5'd1, 5'd31, 5'd5, 5'd16};
	localparam int PHASES     = 8;
	localparam int PHASE_REQS = 105;

	// Shadow allocator: tracks bitmap, counters and registers, and queues the
	// reply word each accepted request should produce.
	class block_ledger;
		logic [WORD_BITS-1:0] map_words [MAP_WORDS];
		logic [GCOUNT_W-1:0]  group_free [NUM_GROUPS];
		logic [TOTAL_W-1:0]   total_free;
		logic                 first_block;
		logic [4:0]           groups_reg;
		rsp_word_t            awaited [$];
		int                   mismatches;

		function new();
			foreach (map_words[i])
				map_words[i] = '0;
			foreach (group_free[g])
				group_free[g] = GCOUNT_W'(BLOCKS_PER_GROUP);
			total_free  = TOTAL_W'(NUM_GROUPS * BLOCKS_PER_GROUP);
			first_block = 1'b1;
			groups_reg  = 5'd16;
			mismatches  = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_FIRST_DATA_BLOCK: first_block = data[0];
				REG_GROUPS_IN_USE:    groups_reg  = data;
				default: ;
			endcase
		endfunction

		function int unsigned active_groups();
			return (groups_reg > NUM_GROUPS) ? NUM_GROUPS : groups_reg;
		endfunction

		// Lowest clear bit of group g, 0 when the group is full
		function bit lowest_clear(int unsigned g, output int unsigned pos);
			pos = 0;
			for (int unsigned w = g * WORDS_PER_GROUP; w < (g + 1) * WORDS_PER_GROUP; w++) begin
				if (map_words[w] != '1) begin
					for (int b = 0; b < WORD_BITS; b++) begin
						if (!map_words[w][b]) begin
							pos = (w - g * WORDS_PER_GROUP) * WORD_BITS + b;
							return 1'b1;
						end
					end
				end
			end
			return 1'b0;
		endfunction

		function rsp_word_t note_request(req_word_t r);
			rsp_word_t   want;
			int unsigned pos, flat, rel, g;
			logic [BLOCK_W-1:0] num;
			want.block_out = '0;
			if (r.action == ACT_ALLOC) begin
				want.status = STAT_NONE;
				for (g = 0; g < active_groups(); g++) begin
					if (group_free[g] == 0)
						continue;
					if (!lowest_clear(g, pos))
						continue;
					flat = g * BLOCKS_PER_GROUP + pos;
					map_words[flat / WORD_BITS][flat % WORD_BITS] = 1'b1;
					group_free[g]--;
					total_free--;
					num = BLOCK_W'(first_block + flat);
					// block number zero is burned and the search moves on
					if (num != 0) begin
						want.block_out = num;
						want.status    = STAT_ALLOC;
						break;
					end
				end
			end else begin
				want.status = STAT_IGNORED;
				if (r.block_in != 0) begin
					rel = r.block_in - first_block;
					g   = rel / BLOCKS_PER_GROUP;
					if (g < active_groups()) begin
						map_words[rel / WORD_BITS][rel % WORD_BITS] = 1'b0;
						group_free[g]++;
						total_free++;
						want.status = STAT_FREED;
					end
				end
			end
			want.free_total_out = total_free;
			awaited.push_back(want);
			return want;
		endfunction

		function void check_reply(rsp_word_t got);
			rsp_word_t want;
			if (awaited.size() == 0) begin
				$error("reply with nothing outstanding: block_out %0d status %0d free_total_out %0d",
					got.block_out, got.status, got.free_total_out);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			if (got.block_out !== want.block_out) begin
				$error("block_out: expected %0d, got %0d", want.block_out, got.block_out);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.free_total_out !== want.free_total_out) begin
				$error("free_total_out: expected %0d, got %0d",
					want.free_total_out, got.free_total_out);
				mismatches++;
			end
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_word_t             req       = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_word_t             rsp;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	block_ledger ledger = new();

	// Block numbers handed out and not yet given back; source of sensible frees
	int unsigned live_blocks [$];

	// Raised by the stimulus to make the receiver start its long hold-off (LONG_HOLD)
	bit hold_asked = 1'b0;

	bitmap_block_allocator #(
		.BLOCKS_PER_GROUP(BLOCKS_PER_GROUP),
		.NUM_GROUPS      (NUM_GROUPS),
		.WORD_BITS       (WORD_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	// Offer one request word and hold it until taken. Valid is left high so a
	// following word can go out on the very next edge; callers drop it.
	task automatic offer(input logic act, input logic [BLOCK_W-1:0] blk);
		req_word_t w;
		rsp_word_t want;
		w.action   = act;
		w.block_in = blk;
		req_valid <= 1'b1;
		req       <= w;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		want = ledger.note_request(w);
		if (want.status == STAT_ALLOC)
			live_blocks.push_back(want.block_out);
	endtask

	// Stop sending and wait until every reply is back, plus a little margin
	task automatic settle();
		req_valid <= 1'b0;
		while (ledger.awaited.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Both registers, then a write to an index that decodes to nothing
	task automatic write_regs(input logic [CFG_DATA_W-1:0] first_val,
			input logic [CFG_DATA_W-1:0] groups_val);
		logic [CFG_IDX_W-1:0]  idx [3];
		logic [CFG_DATA_W-1:0] val [3];
		idx[0] = REG_FIRST_DATA_BLOCK;
		val[0] = first_val;
		idx[1] = REG_GROUPS_IN_USE;
		val[1] = groups_val;
		idx[2] = $urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI;
		val[2] = CFG_DATA_W'($urandom());
		for (int n = 0; n < 3; n++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[n];
			cfg_data  <= val[n];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			ledger.write_reg(idx[n], val[n]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Random request: allocations, frees of live blocks, frees near the live
	// region (often double frees) and the odd wild block number.
	function automatic req_word_t pick_request();
		req_word_t   r;
		int unsigned roll, idx, g, span;
		roll       = $urandom_range(0, 99);
		r.block_in = BLOCK_W'($urandom());
		// keep the live population, and so the scan length, bounded
		if (live_blocks.size() > 240)
			roll = roll / 2 + 50;
		if (roll < 45) begin
			r.action = ACT_ALLOC;
		end else if (roll < 80 && live_blocks.size() != 0) begin
			idx        = $urandom_range(0, live_blocks.size() - 1);
			r.action   = ACT_FREE;
			r.block_in = BLOCK_W'(live_blocks[idx]);
			live_blocks.delete(idx);
		end else if (roll < 92) begin
			r.action   = ACT_FREE;
			g          = $urandom_range(0, NUM_GROUPS - 1);
			span       = ($urandom_range(0, 7) == 0) ? BLOCKS_PER_GROUP - 1 : 511;
			r.block_in = BLOCK_W'(ledger.first_block + g * BLOCKS_PER_GROUP +
				$urandom_range(0, span));
		end else begin
			r.action = ACT_FREE;
		end
		return r;
	endfunction

	// Bursts of words with random gaps; with squeeze set, the receiver holds
	// off while a long first burst keeps coming, so the input backs up.
	task automatic run_phase(input int unsigned count, input bit squeeze);
		int unsigned sent, burst, gap;
		req_word_t   r;
		sent = 0;
		if (squeeze)
			hold_asked = 1'b1;
		while (sent < count) begin
			if (squeeze && sent == 0)
				burst = 24;
			else if ($urandom_range(0, 3) == 0)
				burst = $urandom_range(20, 40);
			else
				burst = $urandom_range(1, 8);
			for (int k = 0; k < burst && sent < count; k++) begin
				r = pick_request();
				offer(r.action, r.block_in);
				sent++;
			end
			gap = $urandom_range(1, 12);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Receiver: checks each reply word taken and stalls in changing patterns
	initial begin : reply_sink
		int unsigned mode, mode_left, held, beat;
		mode      = 0;
		mode_left = 0;
		held      = 0;
		beat      = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				ledger.check_reply(rsp);
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 160);
			end
			mode_left--;
			beat++;
			if (hold_asked) begin
				hold_asked = 1'b0;
				held       = LONG_HOLD;
			end
			if (held != 0) begin
				held--;
				rsp_ready <= 1'b0;
			end else begin
				case (mode)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= 1'($urandom_range(0, 1));
					2: rsp_ready <= ($urandom_range(0, 9) != 0);
					default: rsp_ready <= (beat % 4 == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: first data block 1, all sixteen groups
		offer(ACT_ALLOC, '0);
		offer(ACT_ALLOC, '1);           // block field is ignored on allocate
		offer(ACT_ALLOC, 18'h15555);
		offer(ACT_FREE, '0);            // block zero, ignored
		offer(ACT_FREE, 18'd1);
		offer(ACT_FREE, 18'd2);
		offer(ACT_FREE, 18'd131072);    // last block, never handed out: double free
		offer(ACT_FREE, 18'd131073);    // one past the last group
		offer(ACT_FREE, '1);
		settle();

		// First data block 0 (only bit 0 of the word counts), one group
		write_regs(5'b11110, 5'd1);
		offer(ACT_ALLOC, 18'h2AAAA);    // bit 0 would be block zero: burned, nothing left
		offer(ACT_ALLOC, '0);
		offer(ACT_FREE, 18'd8192);      // group 1 not in use
		offer(ACT_FREE, 18'd8191);      // free block in group 0: double free
		settle();

		// No groups at all
		write_regs(5'd1, 5'd0);
		offer(ACT_ALLOC, '0);
		offer(ACT_FREE, 18'd5);
		settle();

		// Groups above the maximum saturate; clear bit 0 of group 0 again
		write_regs(5'd1, 5'd17);
		offer(ACT_FREE, 18'd1);
		settle();

		// Block zero burned, search goes on into group 1
		write_regs(5'd0, 5'd31);
		offer(ACT_ALLOC, '0);
		offer(ACT_FREE, 18'd131071);
		offer(ACT_FREE, 18'd131072);    // would be group 16
		settle();

		// Random phases, each under its own register settings
		for (int p = 0; p < PHASES; p++) begin
			if (p < 6)
				write_regs(PHASE_FIRST[p], PHASE_GROUPS[p]);
			else
				write_regs(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
			run_phase(PHASE_REQS, p == 2);
			settle();
		end

		// Catch any stray reply word
		repeat (200) @(posedge clk);
		if (ledger.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog, many times the slowest legal run
	initial begin : watchdog
		#4000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
